[rtl/twcs_pkg.sv]
// ----------------------------------------------------------------------------
// twcs_pkg
// Shared types, codes and default sizes of the tile window collision scan.
// ----------------------------------------------------------------------------
package twcs_pkg;

	localparam int DEF_MAX_COLS    = 64;
	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_TILE_PIXELS = 32;
	localparam int DEF_MAX_BOX     = 16;

	localparam int CFG_W   = 7;   // map size register width
	localparam int PIX_W   = 11;  // pixel coordinate width
	localparam int BOXIN_W = 5;   // box size field width

	// configuration register indexes
	typedef enum logic {
		REG_MAP_COLS = 1'b0,
		REG_MAP_ROWS = 1'b1
	} reg_idx_t;

	typedef enum logic {
		FUNC_QUERY = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		DIR_DOWN  = 2'd0,
		DIR_UP    = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_SCAN  = 3'b100
	} state_t;

endpackage

[rtl/tile_window_collision_scan.sv]
// ----------------------------------------------------------------------------
// tile_window_collision_scan
// Tile occupancy map with a box scan that reports the first solid tile.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers on a clock edge with start high and busy low. A write
//   item (func = 1) stores one map bit in that cycle and gives no result; the
//   block is free again on the next cycle. A query item (func = 0) scans the
//   box one tile per cycle through the single map read port, in the order
//   set by direction, and then pulses done for one cycle with hit, hit_x and
//   hit_y. busy stays high from the accepting edge until done.
//   A query ends at the first solid tile or after the last tile of the box;
//   it visits at most width * height tiles (256 for a full 16 x 16 box).
//   An empty box answers without reading any tile. One query at a time.
//   The result is shown for exactly one cycle; the receiver has no stall.
//   After reset the map memory is cleared one tile per cycle, with busy
//   high until all MAX_ROWS * MAX_COLS entries are zero. cfg_we
//   writes map_cols / map_rows at any time; write them only while idle.
// ----------------------------------------------------------------------------
module tile_window_collision_scan
	import twcs_pkg::*;
#(
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int TILE_PIXELS = DEF_TILE_PIXELS,
	parameter int MAX_BOX     = DEF_MAX_BOX
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	// command
	input  logic                start,
	output logic                busy,
	input  logic                func,
	input  logic [1:0]          direction,
	input  logic signed [7:0]   box_x,
	input  logic signed [7:0]   box_y,
	input  logic [BOXIN_W-1:0]  box_width,
	input  logic [BOXIN_W-1:0]  box_height,
	input  logic [5:0]          tile_col,
	input  logic [5:0]          tile_row,
	input  logic                tile_solid,
	// result
	output logic                done,
	output logic                hit,
	output logic [PIX_W-1:0]    hit_x,
	output logic [PIX_W-1:0]    hit_y
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW    = $clog2(MAX_BOX + 1);
	localparam int CW    = 9 + BW;  // signed tile coordinate during scan
	localparam int CNW   = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
	localparam int RNW   = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;

	state_t state_q;

	logic [CFG_W-1:0] map_cols_q, map_rows_q;
	logic [AW-1:0]    clr_q;

	// latched query
	dir_t             dir_q;
	logic signed [7:0] bx_q, by_q;
	logic [BW-1:0]    bw_q, bh_q;
	logic [CNW-1:0]   cols_q;
	logic [RNW-1:0]   rows_q;
	logic [BW-1:0]    a_q, b_q;

	// read stage
	logic             valid_s1, last_s1, inmap_s1;
	logic signed [CW-1:0] c_s1, r_s1;
	logic             rd_s1;

	logic             done_q, hit_q;
	logic [PIX_W-1:0] last_hit_x_q, last_hit_y_q;

	logic             mem [DEPTH];

	logic             accept, is_query;
	logic [BW-1:0]    outer_n, inner_n;
	logic             empty_box, issue, last_issue, inner_end;
	logic signed [CW-1:0] c_cur, r_cur, bx_e, by_e, a_e, b_e;
	logic             inmap_cur;
	logic [AW-1:0]    raddr, waddr;
	logic             we, wdata;
	logic             found, finish;

	assign accept   = start && (state_q == ST_IDLE);
	assign is_query = (func_t'(func) == FUNC_QUERY);

	always_comb begin
		outer_n = ((dir_q == DIR_DOWN) || (dir_q == DIR_UP)) ? bh_q : bw_q;
		inner_n = ((dir_q == DIR_DOWN) || (dir_q == DIR_UP)) ? bw_q : bh_q;
	end

	assign empty_box  = (outer_n == '0) || (inner_n == '0);
	assign issue      = (state_q == ST_SCAN) && !empty_box && (a_q < outer_n);
	assign inner_end  = (b_q == BW'(inner_n - 1'b1));
	assign last_issue = issue && inner_end && (a_q == BW'(outer_n - 1'b1));

	// tile coordinate of the current scan step
	always_comb begin
		bx_e = CW'(bx_q);
		by_e = CW'(by_q);
		a_e  = CW'($signed({1'b0, a_q}));
		b_e  = CW'($signed({1'b0, b_q}));
		unique case (dir_q)
			DIR_DOWN: begin
				r_cur = by_e + a_e;
				c_cur = bx_e + b_e;
			end
			DIR_UP: begin
				r_cur = by_e - a_e;
				c_cur = bx_e + b_e;
			end
			DIR_RIGHT: begin
				c_cur = bx_e + a_e;
				r_cur = by_e + b_e;
			end
			default: begin
				c_cur = bx_e - a_e;
				r_cur = by_e + b_e;
			end
		endcase
	end

	assign inmap_cur = (c_cur >= 0) && (r_cur >= 0) &&
			(int'(c_cur) < int'(cols_q)) && (int'(r_cur) < int'(rows_q));

	// off-map steps read some entry; inmap_s1 masks it
	assign raddr = AW'(int'(r_cur) * MAX_COLS + int'(c_cur));

	assign found  = valid_s1 && inmap_s1 && rd_s1;
	assign finish = found || ((state_q == ST_SCAN) && empty_box) ||
			(valid_s1 && last_s1);

	// single write port: clearing pass or tile write
	always_comb begin
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = 1'b0;
		end else begin
			we    = accept && !is_query &&
					(int'(tile_col) < MAX_COLS) && (int'(tile_row) < MAX_ROWS);
			waddr = AW'(int'(tile_row) * MAX_COLS + int'(tile_col));
			wdata = tile_solid;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cols_q <= CFG_W'(64);
			map_rows_q <= CFG_W'(64);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAP_COLS: map_cols_q <= cfg_data;
				REG_MAP_ROWS: map_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			valid_s1     <= 1'b0;
			done_q       <= 1'b0;
			hit_q        <= 1'b0;
			last_hit_x_q <= '0;
			last_hit_y_q <= '0;
		end else begin
			done_q   <= (state_q == ST_SCAN) && finish;
			valid_s1 <= issue && !finish;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && is_query) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q  <= ST_IDLE;
						hit_q    <= found;
						if (found) begin
							last_hit_x_q <= PIX_W'(int'(c_s1) * TILE_PIXELS);
							last_hit_y_q <= PIX_W'(int'(r_s1) * TILE_PIXELS);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// query latch and scan counters
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			dir_q  <= dir_t'(direction);
			bx_q   <= box_x;
			by_q   <= box_y;
			bw_q   <= (int'(box_width) > MAX_BOX) ? BW'(MAX_BOX) : BW'(box_width);
			bh_q   <= (int'(box_height) > MAX_BOX) ? BW'(MAX_BOX) : BW'(box_height);
			cols_q <= (int'(map_cols_q) > MAX_COLS) ? CNW'(MAX_COLS) : CNW'(map_cols_q);
			rows_q <= (int'(map_rows_q) > MAX_ROWS) ? RNW'(MAX_ROWS) : RNW'(map_rows_q);
			a_q    <= '0;
			b_q    <= '0;
		end else if (issue) begin
			if (inner_end) begin
				b_q <= '0;
				a_q <= a_q + 1'b1;
			end else begin
				b_q <= b_q + 1'b1;
			end
		end
		if (issue) begin
			c_s1     <= c_cur;
			r_s1     <= r_cur;
			inmap_s1 <= inmap_cur;
			last_s1  <= last_issue;
		end
	end

	assign busy  = (state_q != ST_IDLE);
	assign done  = done_q;
	assign hit   = hit_q;
	assign hit_x = last_hit_x_q;
	assign hit_y = last_hit_y_q;

endmodule
